/* src/message_package_deframer_defines.svh */
// Assertion macros used by the checker file.
`ifndef MESSAGE_PACKAGE_DEFRAMER_DEFINES_SVH
`define MESSAGE_PACKAGE_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("message_package_deframer: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("message_package_deframer: assertion failed");

`endif

/* src/mdf_pkg.sv */
package mdf_pkg;

  localparam int unsigned HdrSeqBytes  = 8;
  localparam int unsigned HdrLenBytes  = 2;
  localparam int unsigned HdrTypeBytes = 1;
  localparam int unsigned HdrTotal     = HdrSeqBytes + 2 * HdrLenBytes + HdrTypeBytes;

  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] HdrLastOff   = CountW'(HdrTotal - 1);
  localparam logic [CountW-1:0] HdrSeqEnd    = CountW'(HdrSeqBytes);
  localparam logic [CountW-1:0] HdrTopicEnd  = CountW'(HdrSeqBytes + HdrLenBytes);
  localparam logic [CountW-1:0] HdrMsgEnd    = CountW'(HdrSeqBytes + 2 * HdrLenBytes);

  typedef enum logic [1:0] {
    SEC_HEADER  = 2'd0,
    SEC_TOPIC   = 2'd1,
    SEC_MESSAGE = 2'd2,
    SEC_TRAIL   = 2'd3
  } section_e;

endpackage

/* src/message_package_deframer.sv */
// Package deframer. The input channel takes one raw stream beat per cycle
// (stream_byte_i under in_valid_i / in_stall_o). The output channel gives one
// labeled beat for every input beat (out_valid_o / out_stall_i): the section,
// the byte itself, its offset within the section, the header fields and the
// header_complete and frame_end flags.
// Each package is a 13-byte header, the topic bytes, the message bytes and one
// trailing byte. Header fields read as zero until the last header beat, and
// are held from that beat until the next package's header.
// Output valid rises in the cycle after an input beat is accepted. Throughput is
// one beat per cycle while out_stall_i stays low, set by the single result
// register that sits behind the section counter and the header field registers.
// Reset clears the section state, the offset counter, the header fields and
// the output valid flag; the block then expects the first byte of a header.
// When the receiver stalls while a result is held, in_stall_o rises in the
// same cycle and the held result stays unchanged until it is taken.
module message_package_deframer
  import mdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  section_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] offset_o,
  output logic [63:0] sequence_number_o,
  output logic [15:0] topic_len_o,
  output logic [15:0] message_len_o,
  output logic [7:0]  type_code_o,
  output logic        header_complete_o,
  output logic        frame_end_o
);

  section_e          phase_q, phase_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [63:0]       seq_q, seq_d;
  logic [15:0]       topic_len_q, topic_len_d;
  logic [15:0]       msg_len_q, msg_len_d;
  logic [7:0]        type_q, type_d;

  logic              accept;
  logic              hdr_last;
  logic              topic_last;
  logic              msg_last;
  logic              show;
  section_e          after_topic;
  section_e          after_header;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        section_q;
  logic [7:0]        data_byte_q;
  logic [15:0]       offset_q;
  logic [63:0]       seq_out_q;
  logic [15:0]       topic_out_q;
  logic [15:0]       msg_out_q;
  logic [7:0]        type_out_q;
  logic              hdr_done_q;
  logic              frame_end_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign hdr_last     = (cnt_q >= HdrLastOff);
  assign topic_last   = ({1'b0, cnt_q} + 17'd1) >= {1'b0, topic_len_q};
  assign msg_last     = ({1'b0, cnt_q} + 17'd1) >= {1'b0, msg_len_q};
  assign after_topic  = (msg_len_q != 16'd0) ? SEC_MESSAGE : SEC_TRAIL;
  assign after_header = (topic_len_q != 16'd0) ? SEC_TOPIC : after_topic;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      SEC_HEADER:  if (hdr_last) phase_d = after_header;
      SEC_TOPIC:   if (topic_last) phase_d = after_topic;
      SEC_MESSAGE: if (msg_last) phase_d = SEC_TRAIL;
      SEC_TRAIL:   phase_d = SEC_HEADER;
      default:     phase_d = SEC_HEADER;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q + CountW'(1);
    seq_d       = seq_q;
    topic_len_d = topic_len_q;
    msg_len_d   = msg_len_q;
    type_d      = type_q;
    show        = 1'b1;
    unique case (phase_q)
      SEC_HEADER: begin
        if (cnt_q < HdrSeqEnd) begin
          seq_d = (cnt_q == '0) ? {56'd0, stream_byte_i} : {seq_q[55:0], stream_byte_i};
        end else if (cnt_q < HdrTopicEnd) begin
          topic_len_d = {topic_len_q[7:0], stream_byte_i};
        end else if (cnt_q < HdrMsgEnd) begin
          msg_len_d = {msg_len_q[7:0], stream_byte_i};
        end else begin
          type_d = stream_byte_i;
        end
        if (hdr_last) begin
          cnt_d = '0;
        end else begin
          show = 1'b0;
        end
      end
      SEC_TOPIC:   if (topic_last) cnt_d = '0;
      SEC_MESSAGE: if (msg_last) cnt_d = '0;
      SEC_TRAIL:   cnt_d = '0;
      default:     cnt_d = '0;
    endcase
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= SEC_HEADER;
      cnt_q       <= '0;
      seq_q       <= '0;
      topic_len_q <= '0;
      msg_len_q   <= '0;
      type_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        seq_q       <= seq_d;
        topic_len_q <= topic_len_d;
        msg_len_q   <= msg_len_d;
        type_q      <= type_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      section_q   <= phase_q;
      data_byte_q <= stream_byte_i;
      offset_q    <= (phase_q == SEC_TRAIL) ? 16'd0 : cnt_q;
      seq_out_q   <= show ? seq_d : 64'd0;
      topic_out_q <= show ? topic_len_d : 16'd0;
      msg_out_q   <= show ? msg_len_d : 16'd0;
      type_out_q  <= show ? type_d : 8'd0;
      hdr_done_q  <= (phase_q == SEC_HEADER) && hdr_last;
      frame_end_q <= (phase_q == SEC_TRAIL);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign section_o         = section_q;
  assign data_byte_o       = data_byte_q;
  assign offset_o          = offset_q;
  assign sequence_number_o = seq_out_q;
  assign topic_len_o       = topic_out_q;
  assign message_len_o     = msg_out_q;
  assign type_code_o       = type_out_q;
  assign header_complete_o = hdr_done_q;
  assign frame_end_o       = frame_end_q;

endmodule

/* src/mdf_checker.sv */
`include "message_package_deframer_defines.svh"

module mdf_checker
  import mdf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  section_o,
  input logic [7:0]  data_byte_o,
  input logic [15:0] offset_o,
  input logic [15:0] topic_len_o,
  input logic [7:0]  type_code_o,
  input logic        header_complete_o,
  input logic        frame_end_o
);

  // A trailing beat always closes the package at offset zero.
  `MDF_ASSERT_NOW(a_trail_beat, clk_i, rst_ni, out_valid_o && frame_end_o,
                  section_o == SEC_TRAIL && offset_o == 16'd0 && !header_complete_o)

  // The header completes only on its last beat.
  `MDF_ASSERT_NOW(a_hdr_done, clk_i, rst_ni, out_valid_o && header_complete_o,
                  section_o == SEC_HEADER && offset_o == 16'(HdrTotal - 1))

  // Topic length and type code read as zero before the header is complete.
  `MDF_ASSERT_NOW(a_hdr_hidden, clk_i, rst_ni,
                  out_valid_o && section_o == SEC_HEADER && !header_complete_o,
                  topic_len_o == 16'd0 && type_code_o == 8'd0)

  // Input backpressure only appears while a result is held.
  `MDF_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A stalled result beat is held until taken.
  `MDF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(data_byte_o) && $stable(offset_o))

endmodule

bind message_package_deframer mdf_checker u_mdf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .section_o         (section_o),
  .data_byte_o       (data_byte_o),
  .offset_o          (offset_o),
  .topic_len_o       (topic_len_o),
  .type_code_o       (type_code_o),
  .header_complete_o (header_complete_o),
  .frame_end_o       (frame_end_o)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mdf_pkg::*;

  typedef struct packed {
    section_e    section;
    logic [7:0]  data_byte;
    logic [15:0] offset;
    logic [63:0] sequence_number;
    logic [15:0] topic_len;
    logic [15:0] message_len;
    logic [7:0]  type_code;
    logic        header_complete;
    logic        frame_end;
  } beat_t;

  localparam logic [7:0] TypeMessage   = 8'd77;
  localparam logic [7:0] TypeHeartbeat = 8'd72;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  stream_byte_i = 8'h00;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  section_o;
  logic [7:0]  data_byte_o;
  logic [15:0] offset_o;
  logic [63:0] sequence_number_o;
  logic [15:0] topic_len_o;
  logic [15:0] message_len_o;
  logic [7:0]  type_code_o;
  logic        header_complete_o;
  logic        frame_end_o;

  beat_t       expected_beats[$];
  int          mismatches    = 0;
  int          bytes_sent    = 0;
  bit          sender_idles  = 1'b0;
  bit          receiver_idles = 1'b0;
  bit          hold_pending  = 1'b0;
  int          hold_cycles   = 0;

  section_e    cur_section = SEC_HEADER;
  logic [15:0] byte_idx    = '0;
  logic [63:0] seq_acc     = '0;
  logic [15:0] tlen_acc    = '0;
  logic [15:0] mlen_acc    = '0;
  logic [7:0]  type_acc    = '0;

  message_package_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .stream_byte_i    (stream_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .section_o        (section_o),
    .data_byte_o      (data_byte_o),
    .offset_o         (offset_o),
    .sequence_number_o(sequence_number_o),
    .topic_len_o      (topic_len_o),
    .message_len_o    (message_len_o),
    .type_code_o      (type_code_o),
    .header_complete_o(header_complete_o),
    .frame_end_o      (frame_end_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic beat_t deframe(input logic [7:0] b);
    beat_t r;
    bit    show;
    r = '0;
    show = 1'b1;
    r.section = cur_section;
    r.data_byte = b;
    r.offset = byte_idx;
    case (cur_section)
      SEC_HEADER: begin
        if (byte_idx < HdrSeqEnd) begin
          seq_acc = (byte_idx == 16'd0) ? {56'd0, b} : {seq_acc[55:0], b};
        end else if (byte_idx < HdrTopicEnd) begin
          tlen_acc = {tlen_acc[7:0], b};
        end else if (byte_idx < HdrMsgEnd) begin
          mlen_acc = {mlen_acc[7:0], b};
        end else begin
          type_acc = b;
        end
        if (byte_idx >= HdrLastOff) begin
          r.header_complete = 1'b1;
          byte_idx = '0;
          if (tlen_acc != 16'd0) cur_section = SEC_TOPIC;
          else if (mlen_acc != 16'd0) cur_section = SEC_MESSAGE;
          else cur_section = SEC_TRAIL;
        end else begin
          show = 1'b0;
          byte_idx = byte_idx + 16'd1;
        end
      end
      SEC_TOPIC: begin
        if (int'(byte_idx) + 1 >= int'(tlen_acc)) begin
          byte_idx = '0;
          cur_section = (mlen_acc != 16'd0) ? SEC_MESSAGE : SEC_TRAIL;
        end else begin
          byte_idx = byte_idx + 16'd1;
        end
      end
      SEC_MESSAGE: begin
        if (int'(byte_idx) + 1 >= int'(mlen_acc)) begin
          byte_idx = '0;
          cur_section = SEC_TRAIL;
        end else begin
          byte_idx = byte_idx + 16'd1;
        end
      end
      default: begin
        r.frame_end = 1'b1;
        r.offset = '0;
        byte_idx = '0;
        cur_section = SEC_HEADER;
      end
    endcase
    if (show) begin
      r.sequence_number = seq_acc;
      r.topic_len = tlen_acc;
      r.message_len = mlen_acc;
      r.type_code = type_acc;
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    expected_beats.push_back(deframe(b));
    bytes_sent++;
  endtask

  // Sends a header and then the given number of bytes of the package that follows it.
  task automatic send_package(input logic [63:0] seq, input logic [15:0] tlen,
                              input logic [15:0] mlen, input logic [7:0] type_code,
                              input int body_bytes);
    for (int i = 7; i >= 0; i--) send_byte(seq[8*i +: 8]);
    send_byte(tlen[15:8]);
    send_byte(tlen[7:0]);
    send_byte(mlen[15:8]);
    send_byte(mlen[7:0]);
    send_byte(type_code);
    for (int i = 0; i < body_bytes; i++) send_byte(8'($urandom));
  endtask

  task automatic send_full_package(input logic [63:0] seq, input logic [15:0] tlen,
                                   input logic [15:0] mlen, input logic [7:0] type_code);
    send_package(seq, tlen, mlen, type_code, int'(tlen) + int'(mlen) + 1);
  endtask

  function automatic logic [63:0] random_seq();
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [7:0] random_type();
    case ($urandom_range(0, 2))
      0: return TypeMessage;
      1: return TypeHeartbeat;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_len();
    case ($urandom_range(0, 9))
      0, 1: return 16'd0;
      2: return 16'($urandom_range(9, 40));
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic test_directed_extremes();
    send_full_package(64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, TypeMessage);
    send_full_package(64'h0000_0000_0000_0000, 16'd1, 16'd2, TypeHeartbeat);
  endtask

  task automatic test_random_packages(input int target);
    int stop_at;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        sender_idles = 1'($urandom_range(0, 1));
        receiver_idles = 1'($urandom_range(0, 1));
      end
      send_full_package(random_seq(), random_len(), random_len(), random_type());
    end
  endtask

  task automatic test_long_sections();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    send_full_package(random_seq(), 16'd3, 16'd258, TypeMessage);
  endtask

  task automatic test_receiver_hold_off();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    hold_cycles = 200;
    hold_pending = 1'b1;
    send_full_package(random_seq(), 16'd20, 16'd20, TypeMessage);
    while (hold_pending) @(posedge clk_i);
  endtask

  task automatic test_back_to_back();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    send_full_package(random_seq(), 16'd0, 16'd3, TypeMessage);
    send_full_package(random_seq(), 16'd2, 16'd0, TypeHeartbeat);
    send_full_package(random_seq(), 16'd1, 16'd1, 8'hFF);
    send_full_package(random_seq(), 16'd0, 16'd0, 8'h00);
  endtask

  // The run ends inside this package, so its huge sections never have to be sent.
  task automatic test_max_lengths();
    send_package(random_seq(), 16'hFFFF, 16'hFFFF, 8'hFF, 12);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data_byte %0h",
                 $time, data_byte_o);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("section", 64'(want.section), 64'(section_o));
        check_field("data_byte", 64'(want.data_byte), 64'(data_byte_o));
        check_field("offset", 64'(want.offset), 64'(offset_o));
        check_field("sequence_number", want.sequence_number, sequence_number_o);
        check_field("topic_len", 64'(want.topic_len), 64'(topic_len_o));
        check_field("message_len", 64'(want.message_len), 64'(message_len_o));
        check_field("type_code", 64'(want.type_code), 64'(type_code_o));
        check_field("header_complete", 64'(want.header_complete), 64'(header_complete_o));
        check_field("frame_end", 64'(want.frame_end), 64'(frame_end_o));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_pending = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_random_packages(200);
    test_long_sections();
    test_receiver_hold_off();
    test_back_to_back();
    test_max_lengths();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/mdf_pkg.sv
src/message_package_deframer.sv
src/mdf_checker.sv
dv/testbench.sv
